/* hw/rtl/hbp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants of the harmonic bin packer: register indexes,
// reset values, count width and the sequencer state encoding.
// ----------------------------------------------------------------------------
package hbp_pkg;

   localparam int DEF_MAX_CLASSES = 12;
   localparam int DEF_SIZE_BITS   = 16;

   localparam int COUNT_BITS = 24;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 24'hFF_FFFF;

   localparam int LIMIT_BITS = 4;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd6;

   // reset capacity before truncation to the configured size width
   localparam logic [31:0] CAP_RESET_VAL = 32'd65535;

   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAPACITY = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT    = 1'b1;

   localparam logic MODE_PLACE = 1'b0;
   localparam logic MODE_CLEAR = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_CLASS = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage
`default_nettype wire

/* hw/rtl/harmonic_bin_packer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// harmonic_bin_packer_core
// Online Harmonic-K bin packer with one open bin per size class.
//
// Usage: a request word (req_mode, req_item_size) is taken when req_valid is
// high and req_stall is low. Mode place puts the item in class
// min(K, capacity / size); mode clear empties all bins and zeroes the count.
// Every request gives exactly one response word on the rsp_ channel, taken
// when rsp_valid is high and rsp_stall is low.
// A place request passes from acceptance through the radix-2 restoring
// divider, which forms capacity / size one quotient bit per cycle, then
// through class selection and the final step into the output register. A
// clear request or a rejected size skips the divider and class selection and
// goes straight to the final step. One request is in work at a time;
// req_stall is low only while the sequencer is idle.
// A finished response waits in the output register while rsp_stall is high;
// the next request can be taken meanwhile, and its result holds in the final
// step until the output register frees up.
// Reset (synchronous, active high) empties all bins, zeroes the count and
// loads capacity 65535 and class limit 6. Registers must be written through
// csr_write/csr_index/csr_wdata only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module harmonic_bin_packer_core #(
   parameter int MAX_CLASSES = hbp_pkg::DEF_MAX_CLASSES,
   parameter int SIZE_BITS   = hbp_pkg::DEF_SIZE_BITS,
   localparam int CLASS_BITS = $clog2(MAX_CLASSES + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              csr_write,
   input  wire logic [hbp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [SIZE_BITS-1:0]              csr_wdata,

   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_mode,
   input  wire logic [SIZE_BITS-1:0]              req_item_size,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [CLASS_BITS-1:0]                  rsp_class_index,
   output logic                                   rsp_opened_bin,
   output logic [SIZE_BITS-1:0]                   rsp_class_level,
   output logic [hbp_pkg::COUNT_BITS-1:0]         rsp_bins_used,
   output logic                                   rsp_size_error
);

   localparam int IDX_BITS  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int STEP_BITS = (SIZE_BITS > 1) ? $clog2(SIZE_BITS) : 1;
   localparam int CMP_W     = (SIZE_BITS > CLASS_BITS) ? SIZE_BITS : CLASS_BITS;
   localparam int CNT_W     = hbp_pkg::COUNT_BITS;
   localparam logic [SIZE_BITS-1:0] CAP_RESET = SIZE_BITS'(hbp_pkg::CAP_RESET_VAL);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(SIZE_BITS - 1);
   localparam logic [CMP_W-1:0]     MAX_EXT   = CMP_W'(MAX_CLASSES);

   // configuration
   logic [SIZE_BITS-1:0]              cap_ff;
   logic [hbp_pkg::LIMIT_BITS-1:0]    limit_ff;

   // sequencer and working registers
   hbp_pkg::state_type                state_ff, state_in;
   logic [STEP_BITS-1:0]              step_ff;
   logic                              mode_ff;
   logic                              err_ff;
   logic [SIZE_BITS-1:0]              size_ff;
   logic [SIZE_BITS-1:0]              dvd_ff;   // dividend in, quotient out
   logic [SIZE_BITS-1:0]              rem_ff;
   logic [CLASS_BITS-1:0]             k_ff;
   logic [SIZE_BITS-1:0]              lvl_ff;

   // packer state
   logic [SIZE_BITS-1:0]              levels_ff [MAX_CLASSES];
   logic [CNT_W-1:0]                  count_ff;

   // output register
   logic                              rsp_valid_ff;
   logic [CLASS_BITS-1:0]             rsp_class_ff;
   logic                              rsp_opened_ff;
   logic [SIZE_BITS-1:0]              rsp_level_ff;
   logic [CNT_W-1:0]                  rsp_count_ff;
   logic                              rsp_err_ff;

   logic                              req_take;
   logic                              bad_size;
   logic                              done_go;
   logic [SIZE_BITS:0]                rem_shift;
   logic [SIZE_BITS:0]                rem_diff;
   logic                              q_bit;
   logic [CMP_W-1:0]                  q_ext;
   logic [CMP_W-1:0]                  lim_raw;
   logic [CMP_W-1:0]                  lim;
   logic [CMP_W-1:0]                  k_sel;
   logic [IDX_BITS-1:0]               idx_class;
   logic [IDX_BITS-1:0]               idx_done;
   logic [SIZE_BITS:0]                sum;
   logic                              fits;
   logic [SIZE_BITS-1:0]              new_level;
   logic [CNT_W-1:0]                  count_inc;

   assign req_stall = (state_ff != hbp_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign bad_size  = (req_item_size == '0) || (req_item_size > cap_ff);
   assign done_go   = (state_ff == hbp_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // one restoring-division step
   assign rem_shift = {rem_ff, dvd_ff[SIZE_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, size_ff};
   assign q_bit     = !rem_diff[SIZE_BITS];

   // class = min(limit, quotient); limit clamped into 1..MAX_CLASSES
   assign q_ext   = CMP_W'(dvd_ff);
   assign lim_raw = CMP_W'(limit_ff);
   always_comb begin
      priority if (lim_raw == '0) begin
         lim = CMP_W'(1);
      end else if (lim_raw > MAX_EXT) begin
         lim = MAX_EXT;
      end else begin
         lim = lim_raw;
      end
   end
   assign k_sel     = (q_ext > lim) ? lim : q_ext;
   assign idx_class = IDX_BITS'(k_sel - CMP_W'(1));
   assign idx_done  = IDX_BITS'(k_ff - CLASS_BITS'(1));

   assign sum       = {1'b0, lvl_ff} + {1'b0, size_ff};
   assign fits      = (lvl_ff != '0) && (sum <= {1'b0, cap_ff});
   assign new_level = fits ? sum[SIZE_BITS-1:0] : size_ff;
   assign count_inc = (count_ff != hbp_pkg::COUNT_MAX && !fits) ? count_ff + CNT_W'(1)
                                                                : count_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbp_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_mode == hbp_pkg::MODE_CLEAR || bad_size) begin
                  state_in = hbp_pkg::ST_DONE;
               end else begin
                  state_in = hbp_pkg::ST_DIV;
               end
            end
         end
         hbp_pkg::ST_DIV: begin
            if (step_ff == '0) begin
               state_in = hbp_pkg::ST_CLASS;
            end
         end
         hbp_pkg::ST_CLASS: begin
            state_in = hbp_pkg::ST_DONE;
         end
         hbp_pkg::ST_DONE: begin
            if (done_go) begin
               state_in = hbp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hbp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         limit_ff <= hbp_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            hbp_pkg::CSR_CAPACITY: cap_ff   <= csr_wdata;
            hbp_pkg::CSR_LIMIT:    limit_ff <= csr_wdata[hbp_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // datapath working registers
   always_ff @(posedge clock) begin
      priority if (req_take) begin
         mode_ff <= req_mode;
         // a clear ignores the size field
         err_ff  <= bad_size && (req_mode == hbp_pkg::MODE_PLACE);
         size_ff <= req_item_size;
         dvd_ff  <= cap_ff;
         rem_ff  <= '0;
         step_ff <= STEP_LAST;
      end else if (state_ff == hbp_pkg::ST_DIV) begin
         rem_ff  <= q_bit ? rem_diff[SIZE_BITS-1:0] : rem_shift[SIZE_BITS-1:0];
         dvd_ff  <= {dvd_ff[SIZE_BITS-2:0], q_bit};
         step_ff <= step_ff - STEP_BITS'(1);
      end else if (state_ff == hbp_pkg::ST_CLASS) begin
         k_ff   <= CLASS_BITS'(k_sel);
         lvl_ff <= levels_ff[idx_class];
      end
   end

   // bin levels and count
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_CLASSES; i++) begin
            levels_ff[i] <= '0;
         end
         count_ff <= '0;
      end else if (done_go && !err_ff) begin
         if (mode_ff == hbp_pkg::MODE_CLEAR) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
               levels_ff[i] <= '0;
            end
            count_ff <= '0;
         end else begin
            levels_ff[idx_done] <= new_level;
            count_ff            <= count_inc;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_go) begin
         priority if (mode_ff == hbp_pkg::MODE_CLEAR) begin
            rsp_class_ff  <= '0;
            rsp_opened_ff <= 1'b0;
            rsp_level_ff  <= '0;
            rsp_count_ff  <= '0;
            rsp_err_ff    <= 1'b0;
         end else if (err_ff) begin
            rsp_class_ff  <= '0;
            rsp_opened_ff <= 1'b0;
            rsp_level_ff  <= '0;
            rsp_count_ff  <= count_ff;
            rsp_err_ff    <= 1'b1;
         end else begin
            rsp_class_ff  <= k_ff;
            rsp_opened_ff <= !fits;
            rsp_level_ff  <= new_level;
            rsp_count_ff  <= count_inc;
            rsp_err_ff    <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_class_ff;
   assign rsp_opened_bin  = rsp_opened_ff;
   assign rsp_class_level = rsp_level_ff;
   assign rsp_bins_used   = rsp_count_ff;
   assign rsp_size_error  = rsp_err_ff;

   // a finished word reaches the output register in the next cycle
   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      done_go |=> rsp_valid_ff)
      else $error("finished word did not reach the output register");

   // the divider leaves after its last step into class selection
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbp_pkg::ST_DIV && step_ff == '0) |=> state_ff == hbp_pkg::ST_CLASS)
      else $error("divider did not finish on its last step");

   // a placed item always lands in a class from 1 to MAX_CLASSES
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      (done_go && !err_ff && mode_ff == hbp_pkg::MODE_PLACE)
      |-> (k_ff != '0 && CMP_W'(k_ff) <= MAX_EXT))
      else $error("class index out of range");

   // the count only drops on a clear
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      (done_go && mode_ff == hbp_pkg::MODE_PLACE) |=> count_ff >= $past(count_ff))
      else $error("bin count dropped on a placement");

   // a rejected size reports no class and no new bin
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_class_ff == '0 && !rsp_opened_ff))
      else $error("error word carries a class or an opened bin");

endmodule
`default_nettype wire
